// ===== hdl/dqm_pkg.sv =====
// Shared types and constants for the MFCC DCT and int8 quantization block.
package dqm_pkg;

	localparam int BIN_W = 6;
	localparam int IDX_W = 6;
	localparam int ENERGY_W = 16;
	localparam int SUM_W = 40;
	localparam int SCALE_W = 24;
	localparam int OFFSET_W = 16;
	localparam int ROM_W = 16;
	localparam int VALUE_W = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic [BIN_W-1:0] bin_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// register select is the word address bit
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 16'sd0;

	// Taylor series divisors j*(j+1)
	localparam logic [63:0] COS_DIV [1:8] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};
	localparam logic [63:0] SIN_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic vld;
		bin_t bin;
		logic signed [ENERGY_W-1:0] energy;
	} chain_t;

endpackage

// ===== hdl/dqm_cell.sv =====
// One accumulating cell: cosine column, product stage, running sum and unload hold.
module dqm_cell #(
	parameter int NUM_BINS = 40,
	parameter int COEFF_IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dqm_pkg::chain_t      item_in,
	output dqm_pkg::chain_t      item_out,
	input  logic                 shift,
	input  dqm_pkg::sum_t        hold_in,
	output dqm_pkg::sum_t        hold_out,
	output logic                 done
);

	localparam int BIN_IW = $clog2(NUM_BINS);
	localparam int ROM_DEPTH = 2 ** BIN_IW;

	function automatic logic signed [15:0] rom_entry(input int unsigned n);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] tmp;
		logic [63:0] v;
		logic [63:0] mag;
		logic signed [63:0] acc;
		rem = (64'd1 << 61) / NUM_BINS;
		res = '0;
		for (int i = 0; i < 32; i++) begin
			bit_v = 64'd1 << (62 - 2 * i);
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
		end
		p = (64'(2 * n + 1) * 64'(COEFF_IDX)) % (4 * NUM_BINS);
		q = p / NUM_BINS;
		r = p % NUM_BINS;
		x = (r * dqm_pkg::PI_Q30) / (2 * NUM_BINS);
		x2 = (x * x) >> 30;
		term = q[0] ? x : dqm_pkg::ONE_Q30;
		acc = $signed(term);
		for (int i = 1; i <= 8; i++) begin
			tmp = (term * x2) >> 30;
			if (q[0])
				term = tmp / dqm_pkg::SIN_DIV[i];
			else
				term = tmp / dqm_pkg::COS_DIV[i];
			if (i % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > $signed(dqm_pkg::ONE_Q30))
			acc = $signed(dqm_pkg::ONE_Q30);
		v = $unsigned(acc);
		mag = (res * v + (64'd1 << 44)) >> 45;
		if (mag > 64'd32767)
			mag = 64'd32767;
		if (q == 64'd1 || q == 64'd2)
			return -$signed(16'(mag));
		return $signed(16'(mag));
	endfunction

	logic signed [dqm_pkg::ROM_W-1:0] rom_w [ROM_DEPTH];

	for (genvar n = 0; n < ROM_DEPTH; n++) begin : g_rom
		localparam logic signed [15:0] ENTRY = (n < NUM_BINS) ? rom_entry(n) : 16'sd0;
		assign rom_w[n] = ENTRY;
	end

	dqm_pkg::chain_t item_q;
	logic signed [31:0] prod_s1;
	logic vld_s1;
	logic last_s1;
	dqm_pkg::sum_t sum_q;
	dqm_pkg::sum_t hold_q;
	dqm_pkg::sum_t sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			item_q <= item_in;
			vld_s1 <= item_q.vld;
			last_s1 <= (item_q.bin == dqm_pkg::bin_t'(NUM_BINS - 1));
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= item_q.energy * rom_w[item_q.bin[BIN_IW-1:0]];
	end

	assign sum_next = sum_q + {{(dqm_pkg::SUM_W - 32){prod_s1[31]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (vld_s1) begin
			sum_q <= last_s1 ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && last_s1) begin
			hold_q <= sum_next;
		end else if (shift) begin
			hold_q <= hold_in;
		end
	end

	assign item_out = item_q;
	assign hold_out = hold_q;
	assign done = vld_s1 && last_s1;

endmodule

// ===== hdl/dqm_quant.sv =====
// Quantizer pipeline: scale, offset, round half away from zero, saturate to int8.
module dqm_quant (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	output logic                                  in_rdy,
	input  dqm_pkg::sum_t                         in_sum,
	input  dqm_pkg::idx_t                         in_idx,
	input  logic                                  in_last,
	input  logic [dqm_pkg::SCALE_W-1:0]           scale,
	input  logic signed [dqm_pkg::OFFSET_W-1:0]   offset,
	output logic                                  out_vld,
	input  logic                                  out_stall,
	output logic signed [dqm_pkg::VALUE_W-1:0]    out_value,
	output dqm_pkg::idx_t                         out_idx,
	output logic                                  out_last
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;
	dqm_pkg::idx_t idx_s1, idx_s2, idx_s3, idx_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [43:0] plo_s1;
	logic signed [44:0] phi_s1;
	logic signed [63:0] s_s2;
	logic neg_s3;
	logic [63:0] mag_s3;
	logic signed [dqm_pkg::VALUE_W-1:0] value_s4;
	logic signed [63:0] s_comb;
	logic [63:0] mag_comb;
	logic [24:0] rq;
	logic signed [dqm_pkg::VALUE_W-1:0] value_comb;

	assign ld_s4 = !v_s4 || !out_stall;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;
	assign in_rdy = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_vld;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
		end
	end

	assign s_comb = ({{19{phi_s1[44]}}, phi_s1} <<< 20) + $signed({20'd0, plo_s1})
		+ ({{48{offset[15]}}, offset} <<< 31);

	assign mag_comb = s_s2[63] ? (~$unsigned(s_s2) + ((64'd1 << 38) + 64'd1))
		: ($unsigned(s_s2) + (64'd1 << 38));

	assign rq = mag_s3[63:39];

	always_comb begin
		if (neg_s3) begin
			value_comb = (rq > 25'd128) ? -8'sd128 : -$signed(rq[7:0]);
		end else begin
			value_comb = (rq > 25'd127) ? 8'sd127 : $signed(rq[7:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			plo_s1 <= in_sum[19:0] * scale;
			phi_s1 <= $signed(in_sum[39:20]) * $signed({1'b0, scale});
			idx_s1 <= in_idx;
			last_s1 <= in_last;
		end
		if (ld_s2) begin
			s_s2 <= s_comb;
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
		end
		if (ld_s3) begin
			neg_s3 <= s_s2[63];
			mag_s3 <= mag_comb;
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
		end
		if (ld_s4) begin
			value_s4 <= value_comb;
			idx_s4 <= idx_s3;
			last_s4 <= last_s3;
		end
	end

	assign out_vld = v_s4;
	assign out_value = value_s4;
	assign out_idx = idx_s4;
	assign out_last = last_s4;

endmodule

// ===== hdl/dct_quantize_mfcc.sv =====
// Top level: DCT-II over a frame of log mel energies with int8 quantization of each coefficient.
//
// Energy channel: log_energy with energy_valid / energy_stall, one bin per item,
// bins counted 0..NUM_BINS-1 from reset. Coefficient channel: coeff_value,
// coeff_index and last_coeff with coeff_valid / coeff_stall, NUM_COEFFS items per
// frame in coefficient order. APB port: word 0 reciprocal scale, word 1 offset.
// Throughput: one energy per cycle while energy_stall is low. Each energy runs down a row of NUM_COEFFS cells,
// one cell per cycle, each cell adding energy times its cosine entry into its sum.
// The last bin of a frame parks every sum in the cell's hold register; the holds
// then shift out one a cycle, while the quantizer takes them, into a four-stage quantizer pipeline.
// After the last bin is accepted, coefficients are shown one per cycle while the
// receiver takes them.
// The last bin of the next frame is stalled until all NUM_COEFFS holds of the
// previous frame have entered the quantizer; other bins are never stalled.
// A stalled receiver holds the quantizer, then the hold chain, then that last bin.
// Reset clears sums, bin count and all valid flags; registers return to scale
// 1.0 and offset 0.
module dct_quantize_mfcc #(
	parameter int NUM_BINS = 40,
	parameter int NUM_COEFFS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                energy_valid,
	output logic                                energy_stall,
	input  logic signed [dqm_pkg::ENERGY_W-1:0] log_energy,
	output logic                                coeff_valid,
	input  logic                                coeff_stall,
	output logic signed [dqm_pkg::VALUE_W-1:0]  coeff_value,
	output logic [dqm_pkg::IDX_W-1:0]           coeff_index,
	output logic                                last_coeff,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dqm_pkg::PADDR_W-1:0]         paddr,
	input  logic [dqm_pkg::PDATA_W-1:0]         pwdata,
	output logic [dqm_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int BIN_IW = $clog2(NUM_BINS);
	localparam int CNT_W = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

	logic [dqm_pkg::SCALE_W-1:0] scale_q;
	logic signed [dqm_pkg::OFFSET_W-1:0] offset_q;
	logic [BIN_IW-1:0] bin_cnt_q;
	logic busy_q;
	logic frame_rdy_q;
	logic [CNT_W-1:0] unl_cnt_q;
	logic accept;
	logic at_last_bin;
	logic unl_last;
	logic shift;
	logic q_rdy;

	dqm_pkg::chain_t chain_w [NUM_COEFFS+1];
	dqm_pkg::sum_t hold_w [NUM_COEFFS+1];
	logic done_w [NUM_COEFFS];

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= dqm_pkg::SCALE_RESET;
			offset_q <= dqm_pkg::OFFSET_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				dqm_pkg::REG_SCALE: scale_q <= pwdata[dqm_pkg::SCALE_W-1:0];
				dqm_pkg::REG_OFFSET: offset_q <= $signed(pwdata[dqm_pkg::OFFSET_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dqm_pkg::REG_SCALE: prdata = {8'd0, scale_q};
			dqm_pkg::REG_OFFSET: prdata = {{16{offset_q[15]}}, offset_q};
			default: prdata = '0;
		endcase
	end

	// input side
	assign at_last_bin = (bin_cnt_q == BIN_IW'(NUM_BINS - 1));
	assign energy_stall = busy_q && at_last_bin;
	assign accept = energy_valid && !energy_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
		end else if (accept) begin
			bin_cnt_q <= at_last_bin ? '0 : bin_cnt_q + 1'b1;
		end
	end

	assign chain_w[0] = '{vld: accept, bin: dqm_pkg::bin_t'(bin_cnt_q), energy: log_energy};
	assign hold_w[NUM_COEFFS] = '0;

	for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_cell
		dqm_cell #(
			.NUM_BINS (NUM_BINS),
			.COEFF_IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.item_in (chain_w[k]),
			.item_out(chain_w[k+1]),
			.shift   (shift),
			.hold_in (hold_w[k+1]),
			.hold_out(hold_w[k]),
			.done    (done_w[k])
		);
	end

	// unload of the hold chain
	assign unl_last = (unl_cnt_q == CNT_W'(NUM_COEFFS - 1));
	assign shift = frame_rdy_q && q_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			frame_rdy_q <= 1'b0;
			unl_cnt_q <= '0;
		end else begin
			if (accept && at_last_bin)
				busy_q <= 1'b1;
			else if (shift && unl_last)
				busy_q <= 1'b0;
			if (done_w[NUM_COEFFS-1])
				frame_rdy_q <= 1'b1;
			else if (shift && unl_last)
				frame_rdy_q <= 1'b0;
			if (shift)
				unl_cnt_q <= unl_last ? '0 : unl_cnt_q + 1'b1;
		end
	end

	dqm_quant u_quant (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (frame_rdy_q),
		.in_rdy   (q_rdy),
		.in_sum   (hold_w[0]),
		.in_idx   (dqm_pkg::idx_t'(unl_cnt_q)),
		.in_last  (unl_last),
		.scale    (scale_q),
		.offset   (offset_q),
		.out_vld  (coeff_valid),
		.out_stall(coeff_stall),
		.out_value(coeff_value),
		.out_idx  (coeff_index),
		.out_last (last_coeff)
	);

endmodule
